// ===== sv/steered_odometry_integrator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the steered odometry integrator core
// Concurrent checks written as one-line macro calls in the RTL.
// ----------------------------------------------------------------------------
`ifndef STEERED_ODOMETRY_INTEGRATOR_CORE_ASSERT_SVH
`define STEERED_ODOMETRY_INTEGRATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SOI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("soi assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SOI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("soi assertion failed");

`endif

// ===== sv/soi_pkg.sv =====
// ----------------------------------------------------------------------------
// soi_pkg
// Shared types and constants of the steered odometry integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package soi_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_DIST_PER_COUNT  = 2'd0;
	localparam logic [1:0] CFG_TURN_PER_STEER  = 2'd1;
	localparam logic [1:0] CFG_STEER_NEUTRAL   = 2'd2;

	localparam logic [23:0] RST_DIST_PER_COUNT = 24'd12906;
	localparam logic [19:0] RST_TURN_PER_STEER = 20'd95444;
	localparam logic [7:0]  RST_STEER_NEUTRAL  = 8'd96;

	// Q30 of the reciprocal of the infinite CORDIC gain, used as the start vector.
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	// Result of the CORDIC unit: done level and the rotated unit vector (Q30).
	typedef struct packed {
		logic               done;
		logic signed [32:0] cos_v;
		logic signed [32:0] sin_v;
	} soi_cordic_res_t;

	// Rounded atan(2^-i) in binary angle units, 2^32 = one turn.
	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/soi_cordic.sv =====
// ----------------------------------------------------------------------------
// soi_cordic
// Iterative CORDIC rotation: one shift-add step per cycle on shared adders.
// ----------------------------------------------------------------------------
`default_nettype none

module soi_cordic #(
	parameter int STEPS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [31:0]              ang,
	output soi_pkg::soi_cordic_res_t      res
);

	localparam int ITER_W = $clog2(STEPS);
	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(STEPS - 1);

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ROT,
		CS_FIX
	} cs_state_t;

	cs_state_t              state_q;
	logic [ITER_W-1:0]      iter_q;
	logic                   flip_q;
	logic                   done_q;
	logic signed [33:0]     x_q;
	logic signed [33:0]     y_q;
	logic signed [32:0]     z_q;

	logic signed [32:0]     z_in;
	logic signed [32:0]     z_start;
	logic                   flip_start;
	logic signed [33:0]     xs;
	logic signed [33:0]     ys;
	logic signed [32:0]     atan_v;

	// Angles beyond a quarter turn are folded by half a turn; the result is
	// negated at the end.
	always_comb begin
		z_in = $signed({ang[31], ang});
		z_start = z_in;
		flip_start = 1'b0;
		if (z_in > 33'sd1073741824) begin
			z_start = z_in - 33'sd2147483648;
			flip_start = 1'b1;
		end else if (z_in < -33'sd1073741824) begin
			z_start = z_in + 33'sd2147483648;
			flip_start = 1'b1;
		end
	end

	assign xs = x_q >>> iter_q;
	assign ys = y_q >>> iter_q;
	assign atan_v = $signed({1'b0, soi_pkg::atan_entry(5'(iter_q))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			iter_q <= '0;
			flip_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			case (state_q)
				CS_IDLE: begin
					if (start) begin
						x_q <= soi_pkg::CORDIC_GAIN_Q30;
						y_q <= '0;
						z_q <= z_start;
						flip_q <= flip_start;
						iter_q <= '0;
						done_q <= 1'b0;
						state_q <= CS_ROT;
					end
				end
				CS_ROT: begin
					// A residual angle of zero rotates in the positive direction.
					if (!z_q[32]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - atan_v;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + atan_v;
					end
					if (iter_q == LAST_ITER) begin
						state_q <= CS_FIX;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				CS_FIX: begin
					if (flip_q) begin
						x_q <= -x_q;
						y_q <= -y_q;
					end
					done_q <= 1'b1;
					state_q <= CS_IDLE;
				end
				default: begin
					state_q <= CS_IDLE;
				end
			endcase
		end
	end

	assign res.done = done_q;
	assign res.cos_v = x_q[32:0];
	assign res.sin_v = y_q[32:0];

endmodule

`default_nettype wire

// ===== sv/steered_odometry_integrator_core.sv =====
// ----------------------------------------------------------------------------
// steered_odometry_integrator_core
// Dead-reckoning odometry: encoder distance and steering turn integrated into
// a Q16.16 position and a binary-angle heading.
// ----------------------------------------------------------------------------
// Sequence: an accepted word passes ST_DIST, ST_ROUND, ST_CORD (waiting for the
// CORDIC), ST_MULY and ST_FIN, which registers the result once the output is free.
// Flow: a new word is taken only in ST_IDLE, after the last result is registered;
// the iterative CORDIC (one rotation step per cycle) and the single shared multiplier set the rate.
// Reset: asynchronous and active low; position, heading and the last encoder
// count clear to zero and the configuration registers take their defaults.
`default_nettype none

module steered_odometry_integrator_core #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration.
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [23:0] cfg_wdata,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // encoder_count[31:0], steer_command[39:32],
	                                    // speed_command[48:40], zero fill[55:49]
	// Output stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata    // pos_x[31:0], pos_y[63:32], heading[95:64]
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIST,
		ST_ROUND,
		ST_CORD,
		ST_MULY,
		ST_FIN
	} state_t;

	localparam logic signed [64:0] SAT_MAX   = 65'sd2147483647;
	localparam logic signed [64:0] SAT_MIN   = -65'sd2147483648;
	localparam logic signed [64:0] RND_DIST  = 65'sd128;
	localparam logic signed [64:0] RND_POS   = 65'sd536870912;

	state_t              state_q;

	logic [23:0]         dpc_q;
	logic [19:0]         tps_q;
	logic [7:0]          neutral_q;

	logic [31:0]         last_enc_q;
	logic [31:0]         x_acc_q;
	logic [31:0]         y_acc_q;
	logic [31:0]         heading_q;

	logic [31:0]         enc_q;
	logic [7:0]          steer_q;
	logic                moving_q;
	logic [31:0]         ang_q;
	logic signed [31:0]  dr_q;
	logic [31:0]         dx_q;
	logic signed [64:0]  prod_q;

	logic                m_tvalid_q;
	logic [95:0]         m_tdata_q;

	soi_pkg::soi_cordic_res_t cres;

	logic signed [31:0]  denc;
	logic signed [8:0]   steer_off;
	logic signed [29:0]  turn_p;
	logic [31:0]         turn;
	logic signed [31:0]  mul_a;
	logic signed [32:0]  mul_b;
	logic signed [64:0]  mul_p;
	logic signed [64:0]  dist_sh;
	logic signed [64:0]  pos_sh;
	logic signed [31:0]  dr_sat;
	logic                out_free;

	assign denc = $signed(enc_q - last_enc_q);

	assign steer_off = $signed({1'b0, steer_q}) - $signed({1'b0, neutral_q});
	assign turn_p = 30'(steer_off) * 30'($signed({1'b0, tps_q}));
	assign turn = moving_q ? {{2{turn_p[29]}}, turn_p} : 32'd0;

	// One shared multiplier: distance scaling, then the cos and sin products.
	always_comb begin
		mul_a = dr_q;
		mul_b = cres.sin_v;
		case (state_q)
			ST_DIST: begin
				mul_a = denc;
				mul_b = $signed({9'd0, dpc_q});
			end
			ST_CORD: begin
				mul_b = cres.cos_v;
			end
			default: begin
				mul_b = cres.sin_v;
			end
		endcase
	end

	assign mul_p = $signed({{33{mul_a[31]}}, mul_a}) * $signed({{32{mul_b[32]}}, mul_b});

	assign dist_sh = (prod_q + RND_DIST) >>> 8;
	assign pos_sh = (prod_q + RND_POS) >>> 30;

	always_comb begin
		if (dist_sh > SAT_MAX) begin
			dr_sat = 32'sh7fffffff;
		end else if (dist_sh < SAT_MIN) begin
			dr_sat = 32'sh80000000;
		end else begin
			dr_sat = dist_sh[31:0];
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	soi_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_ROUND),
		.ang    (ang_q),
		.res    (cres)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpc_q <= soi_pkg::RST_DIST_PER_COUNT;
			tps_q <= soi_pkg::RST_TURN_PER_STEER;
			neutral_q <= soi_pkg::RST_STEER_NEUTRAL;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				soi_pkg::CFG_DIST_PER_COUNT: dpc_q <= cfg_wdata;
				soi_pkg::CFG_TURN_PER_STEER: tps_q <= cfg_wdata[19:0];
				soi_pkg::CFG_STEER_NEUTRAL:  neutral_q <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer, odometry state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_enc_q <= '0;
			x_acc_q <= '0;
			y_acc_q <= '0;
			heading_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// In the final state the output register is loaded below instead.
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						enc_q <= s_tdata[31:0];
						steer_q <= s_tdata[39:32];
						moving_q <= (s_tdata[48:40] != 9'd0);
						state_q <= ST_DIST;
					end
				end
				ST_DIST: begin
					prod_q <= mul_p;
					ang_q <= heading_q - turn;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					dr_q <= dr_sat;
					state_q <= ST_CORD;
				end
				ST_CORD: begin
					if (cres.done) begin
						prod_q <= mul_p;
						state_q <= ST_MULY;
					end
				end
				ST_MULY: begin
					dx_q <= pos_sh[31:0];
					prod_q <= mul_p;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						x_acc_q <= x_acc_q + dx_q;
						y_acc_q <= y_acc_q + pos_sh[31:0];
						heading_q <= ang_q;
						last_enc_q <= enc_q;
						m_tdata_q <= {ang_q, y_acc_q + pos_sh[31:0], x_acc_q + dx_q};
						m_tvalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

`include "steered_odometry_integrator_core_assert.svh"

	// Only one word is in work at a time.
	`SOI_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// The rotation finishes only while the sequencer waits for it.
	`SOI_ASSERT_SAME(a_cordic_done_in_wait, clk, arst_n, $rose(cres.done), state_q == ST_CORD)
	// A pending result carries the heading that the state now holds.
	`SOI_ASSERT_SAME(a_heading_matches, clk, arst_n, m_tvalid, m_tdata[95:64] == heading_q)

endmodule

`default_nettype wire

// ===== tb/steered_odometry_integrator_core_checker.sv =====
// ----------------------------------------------------------------------------
// steered_odometry_integrator_core_checker
// Watches the configuration port and both streams of the odometry core, keeps
// its own copy of the pose and the registers, predicts every result word and
// compares it field by field with what the core delivers.
// ----------------------------------------------------------------------------
module steered_odometry_integrator_core_checker #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [23:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam longint Q_MAX    = 64'sd2147483647;
	localparam longint Q_MIN    = -64'sd2147483648;
	localparam longint QUARTER  = 64'sd1073741824;
	localparam longint HALF     = 64'sd2147483648;
	localparam longint ATAN_BAU [30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] hdg;
	} pose_t;

	logic [23:0] dist_per_count;
	logic [19:0] turn_per_unit;
	logic [7:0]  neutral;
	logic [31:0] enc_last;
	logic [31:0] x_pos;
	logic [31:0] y_pos;
	logic [31:0] hdg;
	pose_t       pose_q[$];

	// Integrates one tick into the pose and returns the new pose.
	function automatic pose_t advance_pose(input logic [31:0] enc, input logic [7:0] steer,
			input logic [8:0] speed);
		logic [31:0] du;
		logic [31:0] turn;
		logic [31:0] ang;
		longint      denc;
		longint      dr;
		longint      off;
		longint      prod;
		longint      z;
		longint      cx;
		longint      cy;
		longint      xs;
		longint      ys;
		longint      dx;
		longint      dy;
		bit          flip;
		pose_t       p;
		du = enc - enc_last;
		denc = longint'(signed'(du));
		dr = (denc * longint'(dist_per_count) + 64'sd128) >>> 8;
		if (dr > Q_MAX)
			dr = Q_MAX;
		else if (dr < Q_MIN)
			dr = Q_MIN;
		turn = 32'd0;
		if (speed != 9'd0) begin
			off = longint'(steer) - longint'(neutral);
			prod = off * longint'(turn_per_unit);
			turn = prod[31:0];
		end
		ang = hdg - turn;

		// Fold the angle into +-90 degrees; the rotated vector is negated later.
		z = longint'(signed'(ang));
		flip = 1'b0;
		if (z > QUARTER) begin
			z -= HALF;
			flip = 1'b1;
		end else if (z < -QUARTER) begin
			z += HALF;
			flip = 1'b1;
		end
		cx = GAIN_Q30;
		cy = 0;
		for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (z >= 0) begin
				cx -= ys;
				cy += xs;
				z -= ATAN_BAU[i];
			end else begin
				cx += ys;
				cy -= xs;
				z += ATAN_BAU[i];
			end
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		dx = (dr * cx + 64'sd536870912) >>> 30;
		dy = (dr * cy + 64'sd536870912) >>> 30;
		x_pos += dx[31:0];
		y_pos += dy[31:0];
		hdg = ang;
		enc_last = enc;
		p.x = x_pos;
		p.y = y_pos;
		p.hdg = hdg;
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pose_t want;
		if (!arst_n) begin
			dist_per_count = 24'd12906;
			turn_per_unit = 20'd95444;
			neutral = 8'd96;
			enc_last = 32'd0;
			x_pos = 32'd0;
			y_pos = 32'd0;
			hdg = 32'd0;
			pose_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					soi_pkg::CFG_DIST_PER_COUNT: dist_per_count = cfg_wdata;
					soi_pkg::CFG_TURN_PER_STEER: turn_per_unit = cfg_wdata[19:0];
					soi_pkg::CFG_STEER_NEUTRAL:  neutral = cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (pose_q.size() == 0) begin
					report_mismatch("pose word with nothing pending", m_tdata[31:0], 32'd0);
				end else begin
					want = pose_q.pop_front();
					if (m_tdata[31:0] !== want.x)
						report_mismatch("pos_x", m_tdata[31:0], want.x);
					if (m_tdata[63:32] !== want.y)
						report_mismatch("pos_y", m_tdata[63:32], want.y);
					if (m_tdata[95:64] !== want.hdg)
						report_mismatch("heading", m_tdata[95:64], want.hdg);
				end
			end
			if (s_tvalid && s_tready)
				pose_q.push_back(advance_pose(s_tdata[31:0], s_tdata[39:32], s_tdata[48:40]));
			outstanding <= pose_q.size();
		end
	end

endmodule

// ===== tb/steered_odometry_integrator_core_tb.sv =====
// ----------------------------------------------------------------------------
// steered_odometry_integrator_core_tb
// Drives tick words into the odometry core under several register settings and
// idle patterns; a checker beside the core predicts and compares every pose.
// ----------------------------------------------------------------------------
module steered_odometry_integrator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          STEPS        = 16;
	localparam int          LATENCY      = STEPS + 7;
	localparam int          LIMIT        = 300000;
	localparam int          PHASE_TICKS  = 90;
	localparam logic [1:0]  CFG_UNMAPPED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_addr;
	logic [23:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	int          fail_count;
	int          outstanding;

	int          src_idle_pct = 0;
	int          sink_stall_pct = 0;
	int unsigned cycle_count = 0;
	logic [31:0] enc_cur = 32'd0;
	logic [7:0]  cur_neutral = 8'd96;

	steered_odometry_integrator_core #(.CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	steered_odometry_integrator_core_checker #(.CORDIC_STEPS(STEPS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic set_idling(input int mode);
		case (mode)
			1: begin src_idle_pct = 61; sink_stall_pct = 0; end
			2: begin src_idle_pct = 0; sink_stall_pct = 61; end
			3: begin src_idle_pct = 14; sink_stall_pct = 14; end
			default: begin src_idle_pct = 0; sink_stall_pct = 0; end
		endcase
	endtask

	// Wait until the checker has no pose pending. The first edge lets a word
	// accepted in this step reach the count.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic program_regs(input logic [23:0] dist_val, input logic [19:0] turn,
			input logic [7:0] neutral);
		cfg_wr_en <= 1'b1;
		cfg_addr <= soi_pkg::CFG_DIST_PER_COUNT;
		cfg_wdata <= dist_val;
		@(posedge clk);
		// Upper bits beyond the register width are random and must be dropped.
		cfg_addr <= soi_pkg::CFG_TURN_PER_STEER;
		cfg_wdata <= {4'($urandom()), turn};
		@(posedge clk);
		cfg_addr <= soi_pkg::CFG_STEER_NEUTRAL;
		cfg_wdata <= {16'($urandom()), neutral};
		@(posedge clk);
		// A write to the unmapped index must leave every register alone.
		cfg_addr <= CFG_UNMAPPED;
		cfg_wdata <= 24'($urandom());
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_neutral = neutral;
	endtask

	task automatic send_tick(input logic [31:0] enc, input logic [7:0] steer,
			input logic [8:0] speed);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, speed, steer, enc};
		enc_cur = enc;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic random_tick();
		int          r;
		int          sp;
		logic [31:0] enc;
		logic [7:0]  steer;
		r = $urandom_range(99);
		if (r < 70)
			enc = enc_cur + ($urandom_range(20000) - 10000);
		else if (r < 80)
			enc = $urandom();
		else if (r < 90)
			enc = enc_cur + 32'h7FFF_FFF0 + $urandom_range(31);
		else
			enc = enc_cur ^ 32'h8000_0000;
		r = $urandom_range(99);
		if (r < 8)
			steer = 8'd0;
		else if (r < 16)
			steer = 8'd255;
		else if (r < 24)
			steer = cur_neutral;
		else
			steer = 8'($urandom_range(255));
		r = $urandom_range(99);
		if (r < 15)
			sp = 0;
		else if (r < 20)
			sp = 250;
		else if (r < 25)
			sp = -250;
		else
			sp = int'($urandom_range(500)) - 250;
		send_tick(enc, steer, sp[8:0]);
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_wr_en <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_regs(soi_pkg::RST_DIST_PER_COUNT, soi_pkg::RST_TURN_PER_STEER,
				soi_pkg::RST_STEER_NEUTRAL);
		set_idling(0);

		// First tick is measured against a zero count.
		send_tick(32'd1000, 8'd96, 9'sd100);
		send_tick(32'd1000, 8'd96, 9'sd100);
		// Jump to the largest count: the distance step saturates.
		send_tick(32'h7FFF_FFFF, 8'd255, 9'sd250);
		// Crossing the sign boundary of the count is a difference of one.
		send_tick(32'h8000_0000, 8'd0, -9'sd250);
		// Zero speed keeps the heading even with the steering far off neutral.
		send_tick(32'h8000_1388, 8'd200, 9'sd0);
		send_tick(32'h7FFF_FF00, 8'd96, -9'sd1);
		// A huge backward jump saturates to the negative limit.
		send_tick(32'h0000_0000, 8'd0, 9'sd1);
		send_tick(32'hFFFF_FFFF, 8'd255, 9'sd250);
		send_tick(32'h0000_0064, 8'd0, 9'sd250);
		send_tick(32'h0000_00C8, 8'd0, 9'sd250);
		send_tick(32'h0000_012C, 8'd255, -9'sd250);
		send_tick(32'h0000_0190, 8'd95, 9'sd1);
		send_tick(32'h0000_0190, 8'd97, 9'sd0);

		for (int phase = 0; phase < 6; phase++) begin
			if (phase > 0) begin
				drain();
				case (phase)
					1: program_regs(24'hFF_FFFF, 20'hF_FFFF, 8'd0);
					2: program_regs(24'd0, 20'd0, 8'd255);
					3: program_regs(24'($urandom_range(65535)), 20'($urandom_range(1048575)),
							8'($urandom_range(255)));
					4: program_regs(24'($urandom()), 20'($urandom_range(1048575)),
							8'($urandom_range(255)));
					default: program_regs(soi_pkg::RST_DIST_PER_COUNT, 20'hF_FFFF,
							soi_pkg::RST_STEER_NEUTRAL);
				endcase
			end
			set_idling(phase % 4);
			for (int n = 0; n < PHASE_TICKS; n++) begin
				random_tick();
				if ($urandom_range(39) == 0)
					drain();
			end
		end

		drain();
		repeat (LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/soi_pkg.sv
sv/soi_cordic.sv
sv/steered_odometry_integrator_core.sv
tb/steered_odometry_integrator_core_checker.sv
tb/steered_odometry_integrator_core_tb.sv
